// ----- design/fractional_power_free_checker_defines.svh -----
// Assertion macros used by the checker file of the fractional power free checker.
// Depends on nothing; the including file supplies clock, reset and the signals.
`ifndef FRACTIONAL_POWER_FREE_CHECKER_DEFINES_SVH
`define FRACTIONAL_POWER_FREE_CHECKER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FPF_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FPF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/fpf_pkg.sv -----
// Package of the fractional power free checker: widths, codes, control types.
// Used by fpf_cell and fractional_power_free_checker; depends on nothing.
`default_nettype none

package fpf_pkg;

   localparam int LETTER_W = 6;
   localparam int RUN_W    = 8;
   localparam int CFG_W    = 8;
   localparam int BAD_W    = 8;
   localparam int CSR_IDX_W = 1;

   localparam logic [RUN_W-1:0] RUN_MAX = 8'd255;
   localparam logic [BAD_W-1:0] BAD_MAX = 8'd255;

   localparam logic [CFG_W-1:0] ALPHA_NUM_RST = 8'd7;
   localparam logic [CFG_W-1:0] ALPHA_DEN_RST = 8'd4;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_ALPHA_NUM = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_ALPHA_DEN = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_SCAN,
      ST_HOLD
   } fpf_state_type;

   // Control broadcast from the sequencer to every cell of the row.
   typedef struct packed {
      logic accept;   // an item is taken at this edge
      logic clear;    // that item starts a new word
      logic shift;    // move the failure flags one cell toward period one
   } cell_ctl_type;

endpackage

`default_nettype wire

// ----- design/fpf_cell.sv -----
// One period cell: holds the letter PERIOD places back, its run count and a failure flag.
// Depends on fpf_pkg.
`default_nettype none

module fpf_cell #(
   parameter int PERIOD = 1,
   parameter int PW     = 8
) (
   input  wire                              clock,
   input  wire                              reset,
   input  fpf_pkg::cell_ctl_type            ctl,
   input  wire  [fpf_pkg::LETTER_W-1:0]     letter_in,
   input  wire  [fpf_pkg::LETTER_W-1:0]     prev_letter,
   input  wire                              prev_valid,
   input  wire  [fpf_pkg::CFG_W-1:0]        alpha_num,
   input  wire  [fpf_pkg::CFG_W-1:0]        alpha_den,
   input  wire                              next_fail,
   output logic [fpf_pkg::LETTER_W-1:0]     letter_out,
   output logic                             valid_out,
   output logic                             fail_out
);

   localparam int SW    = ((PW > fpf_pkg::RUN_W) ? PW : fpf_pkg::RUN_W) + 1;
   localparam int PRODW = SW + fpf_pkg::CFG_W;

   logic [fpf_pkg::LETTER_W-1:0] letter_ff;
   logic                         valid_ff, valid_in;
   logic [fpf_pkg::RUN_W-1:0]    run_ff, run_in, run_inc;
   logic                         fail_ff, fail_in;
   logic                         active, match, hit;
   logic [SW-1:0]                span;
   logic [PRODW-1:0]             lhs, rhs;

   always_comb begin
      active  = valid_ff && !ctl.clear;
      match   = (letter_ff == letter_in);
      run_inc = (run_ff == fpf_pkg::RUN_MAX) ? run_ff : run_ff + 1'b1;
      span    = SW'(run_inc) + SW'(PERIOD);
      lhs     = PRODW'(span) * PRODW'(alpha_den);
      rhs     = PRODW'(alpha_num) * PRODW'(PERIOD);
      hit     = active && match && (lhs > rhs);

      // The first cell always receives the new letter; later cells inherit their
      // neighbor's flag unless a new word begins.
      valid_in = (PERIOD == 1) ? 1'b1 : (prev_valid && !ctl.clear);

      if (ctl.clear) begin
         run_in = '0;
      end else if (active) begin
         run_in = match ? run_inc : '0;
      end else begin
         run_in = run_ff;
      end

      if (ctl.accept) begin
         fail_in = hit;
      end else if (ctl.shift) begin
         fail_in = next_fail;
      end else begin
         fail_in = fail_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.accept) begin
         letter_ff <= prev_letter;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         run_ff   <= '0;
         fail_ff  <= 1'b0;
      end else begin
         if (ctl.accept) begin
            valid_ff <= valid_in;
            run_ff   <= run_in;
         end
         fail_ff <= fail_in;
      end
   end

   assign letter_out = letter_ff;
   assign valid_out  = valid_ff;
   assign fail_out   = fail_ff;

endmodule

`default_nettype wire

// ----- design/fractional_power_free_checker.sv -----
// Sequence: an accepted item updates the cell row, then the evaluate step registers the result
// when the item causes no new failure; an item that first fails the word first passes through
// the scan state, which finds k, the smallest failing period, while the failure flags shift
// down the cell row to period one. A new item is taken only in the idle state, so the block
// cannot take one before the last result is registered, and a stalled result holds it off.
// Reset is synchronous and active high: word history, runs and the output valid flag are cleared,
// alpha_num returns to 7 and alpha_den to 4.
`default_nettype none

module fractional_power_free_checker #(
   parameter int MAX_LEN = 256
) (
   input  wire                                clock,
   input  wire                                reset,
   // Input items.
   input  wire                                req_tvalid,
   output logic                               req_tready,
   input  wire  [7:0]                         req_tdata,   // [5:0] letter, [7:6] zero
   input  wire                                req_tuser,   // [0] starts_word
   // Result items.
   output logic                               rsp_tvalid,
   input  wire                                rsp_tready,
   output logic [15:0]                        rsp_tdata,   // [0] is_free, [8:1] bad_period,
                                                           // [9] too_long, [15:10] zero
   // Configuration writes.
   input  wire                                csr_we,
   input  wire  [fpf_pkg::CSR_IDX_W-1:0]      csr_addr,
   input  wire  [fpf_pkg::CFG_W-1:0]          csr_wdata
);

   // One cell per checked period, periods 1 .. MAX_LEN-1.
   localparam int NCELL = MAX_LEN - 1;
   localparam int PW    = $clog2(MAX_LEN);
   // The length counter stops at MAX_LEN+1.
   localparam int LW    = $clog2(MAX_LEN + 2);
   localparam int CW    = PW + fpf_pkg::BAD_W;

   // Configuration registers.
   logic [fpf_pkg::CFG_W-1:0] alpha_num_ff, alpha_den_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_num_ff <= fpf_pkg::ALPHA_NUM_RST;
         alpha_den_ff <= fpf_pkg::ALPHA_DEN_RST;
      end else if (csr_we) begin
         unique case (csr_addr)
            fpf_pkg::CSR_ALPHA_NUM: begin
               alpha_num_ff <= csr_wdata;
            end
            fpf_pkg::CSR_ALPHA_DEN: begin
               alpha_den_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   // Sequencer state and word status.
   fpf_pkg::fpf_state_type state_ff, state_in;
   fpf_pkg::cell_ctl_type  ctl;

   logic                      accept, clear;
   logic [LW-1:0]             len_ff, len_in, len_base;
   logic                      failed_ff, failed_in;
   logic [fpf_pkg::BAD_W-1:0] bad_ff, bad_in;
   logic [PW-1:0]             cnt_ff, cnt_in;
   logic [CW-1:0]             cnt_wide;
   logic                      res_done, slot_free, load;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [15:0]               rsp_data_ff, rsp_data_in;
   logic                      too_long;

   // Cell row interconnect.
   logic [fpf_pkg::LETTER_W-1:0] letter_chain [NCELL];
   logic [NCELL-1:0]             valid_chain;
   logic [NCELL-1:0]             fail_vec;
   logic                         any_fail, head_fail;

   assign req_tready = (state_ff == fpf_pkg::ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign clear      = req_tuser;

   assign any_fail  = |fail_vec;
   assign head_fail = fail_vec[0];

   always_comb begin
      ctl.accept = accept;
      ctl.clear  = clear;
      ctl.shift  = (state_ff == fpf_pkg::ST_SCAN) && !head_fail;
   end

   // The row: cell k checks period k+1. Letters and valid flags move one cell per
   // accepted item, failure flags move one cell toward period one while scanning.
   for (genvar k = 0; k < NCELL; k++) begin : g_cell
      logic [fpf_pkg::LETTER_W-1:0] prev_letter;
      logic                         prev_valid;
      logic                         next_fail;

      if (k == 0) begin : g_first
         assign prev_letter = req_tdata[fpf_pkg::LETTER_W-1:0];
         assign prev_valid  = 1'b1;
      end else begin : g_inner
         assign prev_letter = letter_chain[k-1];
         assign prev_valid  = valid_chain[k-1];
      end

      if (k == NCELL - 1) begin : g_last
         assign next_fail = 1'b0;
      end else begin : g_mid
         assign next_fail = fail_vec[k+1];
      end

      fpf_cell #(
         .PERIOD (k + 1),
         .PW     (PW)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .letter_in   (req_tdata[fpf_pkg::LETTER_W-1:0]),
         .prev_letter (prev_letter),
         .prev_valid  (prev_valid),
         .alpha_num   (alpha_num_ff),
         .alpha_den   (alpha_den_ff),
         .next_fail   (next_fail),
         .letter_out  (letter_chain[k]),
         .valid_out   (valid_chain[k]),
         .fail_out    (fail_vec[k])
      );
   end

   // Word length saturates one past MAX_LEN, which is all too_long needs.
   always_comb begin
      len_base = clear ? '0 : len_ff;
      len_in   = len_base + LW'(len_base <= LW'(MAX_LEN));
   end

   assign too_long  = (len_ff > LW'(MAX_LEN));
   assign slot_free = !rsp_valid_ff || rsp_tready;
   assign cnt_wide  = CW'(cnt_ff);

   // Next state and word status. A failure is recorded only when the word was still
   // free; the scan then finds the smallest period whose cell raised its flag.
   always_comb begin
      state_in  = state_ff;
      failed_in = failed_ff;
      bad_in    = bad_ff;
      cnt_in    = cnt_ff;
      res_done  = 1'b0;

      unique case (state_ff)
         fpf_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = fpf_pkg::ST_EVAL;
               if (clear) begin
                  failed_in = 1'b0;
                  bad_in    = '0;
               end
            end
         end
         fpf_pkg::ST_EVAL: begin
            if (!failed_ff && any_fail) begin
               state_in = fpf_pkg::ST_SCAN;
               cnt_in   = PW'(1);
            end else begin
               res_done = 1'b1;
            end
         end
         fpf_pkg::ST_SCAN: begin
            if (head_fail) begin
               failed_in = 1'b1;
               bad_in    = (cnt_wide > CW'(fpf_pkg::BAD_MAX)) ?
                           fpf_pkg::BAD_MAX : cnt_wide[fpf_pkg::BAD_W-1:0];
               res_done  = 1'b1;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         fpf_pkg::ST_HOLD: begin
            res_done = 1'b1;
         end
         default: begin
            state_in = fpf_pkg::ST_IDLE;
         end
      endcase

      // A finished result goes straight to the output register when it is free,
      // and otherwise waits in the hold state.
      load = res_done && slot_free;
      if (res_done) begin
         state_in = slot_free ? fpf_pkg::ST_IDLE : fpf_pkg::ST_HOLD;
      end
   end

   always_comb begin
      rsp_data_in        = '0;
      rsp_data_in[0]     = !failed_in;
      rsp_data_in[8:1]   = failed_in ? bad_in : '0;
      rsp_data_in[9]     = too_long;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_tready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fpf_pkg::ST_IDLE;
         len_ff       <= '0;
         failed_ff    <= 1'b0;
         bad_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         failed_ff    <= failed_in;
         bad_ff       <= bad_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            len_ff <= len_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

// ----- design/fpf_sva_checker.sv -----
// Port-level checks for the fractional power free checker, bound to its top level.
// Depends on fractional_power_free_checker_defines.svh.
`default_nettype none

`include "fractional_power_free_checker_defines.svh"

module fpf_sva_checker (
   input wire        clock,
   input wire        reset,
   input wire        rsp_tvalid,
   input wire        rsp_tready,
   input wire [15:0] rsp_tdata
);

   `FPF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid, "result item dropped while stalled")
   `FPF_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tdata), "result item changed while stalled")
   `FPF_ASSERT_SAME(a_free_no_period, clock, reset, rsp_tvalid && rsp_tdata[0], rsp_tdata[8:1] == 8'd0, "free word reports a period")
   `FPF_ASSERT_SAME(a_fail_has_period, clock, reset, rsp_tvalid && !rsp_tdata[0], rsp_tdata[8:1] != 8'd0, "failed word reports no period")

endmodule

bind fractional_power_free_checker fpf_sva_checker u_fpf_sva_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

// ----- verif/tb_fractional_power_free_checker.sv -----
// Self-checking testbench for fractional_power_free_checker: letter items stream in, and
// every result item is checked against a typed verdict or a predictor of the fractional power test.
// Depends on fpf_pkg and the fractional_power_free_checker RTL.
`default_nettype none

module tb_fractional_power_free_checker;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WORD_MAX    = 256;   // MAX_LEN of the instance under test
   localparam int QUIET_LIMIT = 4000;  // cycles in which no item is accepted on either side before giving up
   localparam int PHASES      = 12;
   localparam int PHASE_ITEMS = 70;

   // One result item, in the order of its fields.
   typedef struct packed {
      logic       is_free;
      logic [7:0] bad_period;
      logic       too_long;
   } word_verdict_type;

   // One row of the directed table. When known is set the verdict is typed in by hand;
   // otherwise the predictor supplies it.
   typedef struct {
      logic [5:0]       letter;
      bit               starts;
      bit               known;
      word_verdict_type verdict;
   } letter_row_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   logic [7:0]                    req_tdata = '0;   // [5:0] letter, [7:6] zero
   logic                          req_tuser = 1'b0; // [0] starts_word
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   logic [15:0]                   rsp_tdata;        // [0] is_free, [8:1] bad_period, [9] too_long
   logic                          csr_we = 1'b0;
   logic [fpf_pkg::CSR_IDX_W-1:0] csr_addr = '0;
   logic [fpf_pkg::CFG_W-1:0]     csr_wdata = '0;

   fractional_power_free_checker #(
      .MAX_LEN(WORD_MAX)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // ------------------------------------------------------------------------------------
   // Predictor state: our own copy of the word history, the per-period match runs, the
   // sticky failure and the two threshold registers.
   // ------------------------------------------------------------------------------------
   logic [5:0]       letter_ring [WORD_MAX];
   int               match_run [WORD_MAX];
   int               word_len;
   int               ring_head;
   bit               word_failed;
   int               failed_period;
   int               alpha_num_q = int'(fpf_pkg::ALPHA_NUM_RST);
   int               alpha_den_q = int'(fpf_pkg::ALPHA_DEN_RST);

   word_verdict_type verdicts_due [$];   // expected results, oldest first
   int               mismatches = 0;
   int               quiet_cycles = 0;
   int               hold_off_req = 0;   // a long receiver stall requested by the stimulus
   bit               src_steady = 1'b0;  // sender offers back to back when set
   bit               sink_steady = 1'b0; // receiver never stalls on its own when set

   // A new word (or reset) forgets everything about the previous one.
   function automatic void clear_word();
      for (int p = 0; p < WORD_MAX; p++) begin
         match_run[p] = 0;
      end
      word_len      = 0;
      ring_head     = 0;
      word_failed   = 1'b0;
      failed_period = 0;
   endfunction

   // Takes one letter into the predicted word and returns the verdict on the word so far.
   // A period p is tested only when the letter equals the one p places back; the word
   // fails when (run + p) * den > num * p, with the run saturating at 255.
   function automatic word_verdict_type next_verdict(logic [5:0] letter, bit starts);
      int               span;
      int               slot;
      int               run;
      word_verdict_type v;
      if (starts) begin
         clear_word();
      end
      span = (word_len > WORD_MAX - 1) ? WORD_MAX - 1 : word_len;
      for (int p = 1; p <= span; p++) begin
         slot = (ring_head - p + WORD_MAX) % WORD_MAX;
         if (letter_ring[slot] == letter) begin
            run = (match_run[p] < 255) ? match_run[p] + 1 : 255;
            match_run[p] = run;
            if ((run + p) * alpha_den_q > alpha_num_q * p && !word_failed) begin
               word_failed   = 1'b1;
               failed_period = (p > 255) ? 255 : p;
            end
         end else begin
            match_run[p] = 0;
         end
      end
      letter_ring[ring_head] = letter;
      ring_head = (ring_head + 1) % WORD_MAX;
      if (word_len <= WORD_MAX) begin
         word_len++;
      end
      v.is_free    = !word_failed;
      v.bad_period = word_failed ? 8'(failed_period) : 8'd0;
      v.too_long   = (word_len > WORD_MAX);
      return v;
   endfunction

   // Idle lengths shared by both sides: mostly none or short, now and then a long one.
   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) begin
         return 0;
      end else if (r < 88) begin
         return $urandom_range(1, 3);
      end else if (r < 97) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 60);
   endfunction

   // Offers one letter item, starting at a falling edge, and returns at the falling edge
   // after the item was accepted. tvalid stays high on return so that a following item
   // with no gap goes out back to back; the caller lowers it when the stream pauses.
   task automatic send_letter(input logic [5:0] letter, input bit starts, input bit known,
                              input word_verdict_type typed_verdict);
      int               gap;
      word_verdict_type v;
      gap = src_steady ? 0 : gap_length();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, letter};
      req_tuser  <= starts;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      v = next_verdict(letter, starts);
      verdicts_due.push_back(known ? typed_verdict : v);
      @(negedge clock);
   endtask

   // Writes both threshold registers, starting and ending at a falling edge.
   task automatic set_alpha(input int num, input int den);
      csr_we    <= 1'b1;
      csr_addr  <= fpf_pkg::CSR_ALPHA_NUM;
      csr_wdata <= fpf_pkg::CFG_W'(num);
      @(negedge clock);
      csr_addr  <= fpf_pkg::CSR_ALPHA_DEN;
      csr_wdata <= fpf_pkg::CFG_W'(den);
      @(negedge clock);
      csr_we    <= 1'b0;
      alpha_num_q = num;
      alpha_den_q = den;
   endtask

   // Directed rows, run under the reset thresholds 7/4. With those, two equal letters in a
   // row fail at period 1, and the square "x y x y" fails at period 2.
   letter_row_type directed_rows [20] = '{
      // A stream without a word start continues the empty word left by reset.
      '{6'd0,  1'b0, 1'b1, '{1'b1, 8'd0, 1'b0}},
      '{6'd63, 1'b0, 1'b1, '{1'b1, 8'd0, 1'b0}},
      '{6'd63, 1'b0, 1'b1, '{1'b0, 8'd1, 1'b0}},
      // Failure is sticky until the next word start.
      '{6'd5,  1'b0, 1'b1, '{1'b0, 8'd1, 1'b0}},
      '{6'd5,  1'b1, 1'b1, '{1'b1, 8'd0, 1'b0}},
      '{6'd6,  1'b0, 1'b1, '{1'b1, 8'd0, 1'b0}},
      '{6'd5,  1'b0, 1'b1, '{1'b1, 8'd0, 1'b0}},
      '{6'd6,  1'b0, 1'b1, '{1'b0, 8'd2, 1'b0}},
      // The runs keep moving after failure while the first failing period is kept.
      '{6'd5,  1'b0, 1'b1, '{1'b0, 8'd2, 1'b0}},
      '{6'd1,  1'b1, 1'b0, '0},
      '{6'd2,  1'b0, 1'b0, '0},
      '{6'd3,  1'b0, 1'b0, '0},
      '{6'd1,  1'b0, 1'b0, '0},
      '{6'd2,  1'b0, 1'b0, '0},
      '{6'd3,  1'b0, 1'b0, '0},
      '{6'd1,  1'b0, 1'b0, '0},
      '{6'd42, 1'b1, 1'b0, '0},
      '{6'd21, 1'b0, 1'b0, '0},
      '{6'd42, 1'b0, 1'b0, '0},
      '{6'd21, 1'b0, 1'b0, '0}
   };

   // Threshold settings of the first phases: the extremes, zero in either register, and
   // the reset value again. Later phases draw both registers at random.
   int phase_num [7] = '{1, 255, 0, 9, 255, 1, 7};
   int phase_den [7] = '{1, 255, 7, 0, 1,   255, 4};

   // ------------------------------------------------------------------------------------
   // Stimulus: reset, the directed table, then phases of random words under changing
   // thresholds. Registers are only written once every expected result has arrived.
   // ------------------------------------------------------------------------------------
   initial begin
      int         made;
      int         q;
      int         len;
      int         k;
      int         base;
      int         flaw;
      int         style;
      logic [5:0] pick;
      logic [5:0] pattern [8];

      clear_word();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         send_letter(directed_rows[r].letter, directed_rows[r].starts,
                     directed_rows[r].known, directed_rows[r].verdict);
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         req_tvalid <= 1'b0;
         while (verdicts_due.size() != 0) begin
            @(negedge clock);
         end
         repeat (8) @(negedge clock);
         if (phase < 7) begin
            set_alpha(phase_num[phase], phase_den[phase]);
         end else begin
            set_alpha($urandom_range(0, 255), $urandom_range(0, 255));
         end
         src_steady  = (phase % 4 == 1);
         sink_steady = (phase % 3 == 2);
         // Hold the receiver off for a long stretch while the sender keeps offering,
         // so the block fills up and has to stall its input.
         if (phase == 1) begin
            hold_off_req = 300;
         end
         made = 0;

         // Long words of one letter: they push past MAX_LEN and saturate the runs. With
         // 255/1 the period-one run fails exactly when it reaches 255; with a zero
         // denominator nothing ever fails.
         if (phase == 3 || phase == 4) begin
            pick = 6'($urandom_range(0, 63));
            for (int i = 0; i < 300; i++) begin
               send_letter(pick, i == 0, 1'b0, '0);
            end
            made += 300;
         end

         while (made < PHASE_ITEMS) begin
            style = $urandom_range(0, 99);
            if (style < 55) begin
               // Periodic word with random content, sometimes broken by one wrong letter
               // after the first period.
               q    = $urandom_range(1, 8);
               len  = $urandom_range(q + 1, 3 * q + 4);
               base = $urandom_range(0, 63);
               k    = $urandom_range(2, 8);
               for (int i = 0; i < q; i++) begin
                  pattern[i] = 6'(base + $urandom_range(0, k - 1));
               end
               flaw = ($urandom_range(0, 9) < 3) ? $urandom_range(q, len - 1) : -1;
               for (int i = 0; i < len; i++) begin
                  pick = pattern[i % q];
                  if (i == flaw) begin
                     pick = pick ^ 6'($urandom_range(1, 63));
                  end
                  send_letter(pick, i == 0, 1'b0, '0);
               end
               made += len;
            end else if (style < 90) begin
               // Word over a small alphabet; now and then a long one.
               k    = $urandom_range(2, 4);
               base = $urandom_range(0, 63);
               len  = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(3, 20);
               for (int i = 0; i < len; i++) begin
                  send_letter(6'(base + $urandom_range(0, k - 1)), i == 0, 1'b0, '0);
               end
               made += len;
            end else begin
               // Noise: any letter, word start or not.
               send_letter(6'($urandom_range(0, 63)), $urandom_range(0, 1), 1'b0, '0);
               made++;
            end
         end
      end

      req_tvalid <= 1'b0;
      while (verdicts_due.size() != 0) begin
         @(posedge clock);
      end
      // Give a stray extra result time to show up.
      repeat (64) @(posedge clock);
      if (mismatches == 0 && verdicts_due.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // ------------------------------------------------------------------------------------
   // Receiver: ready changes at the falling edge. It stalls at random unless told to be
   // steady, and serves a long hold-off when the stimulus asks for one.
   // ------------------------------------------------------------------------------------
   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (hold_off_req > 0) begin
            stall_left   = hold_off_req;
            hold_off_req = 0;
         end
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
            if (!sink_steady) begin
               stall_left = gap_length();
            end
         end
      end
   end

   // ------------------------------------------------------------------------------------
   // Result check: every accepted result item is compared with the oldest expectation.
   // ------------------------------------------------------------------------------------
   word_verdict_type seen_verdict;
   word_verdict_type due_verdict;

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen_verdict.is_free    = rsp_tdata[0];
         seen_verdict.bad_period = rsp_tdata[8:1];
         seen_verdict.too_long   = rsp_tdata[9];
         if (verdicts_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("%0t: result item with nothing expected: tdata=%h", $realtime,
                        rsp_tdata);
            end
         end else begin
            due_verdict = verdicts_due.pop_front();
            if (seen_verdict !== due_verdict) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("%0t: mismatch: expected is_free=%0b bad_period=%0d too_long=%0b",
                           $realtime, due_verdict.is_free, due_verdict.bad_period,
                           due_verdict.too_long);
                  $display("%0t:           got      is_free=%0b bad_period=%0d too_long=%0b",
                           $realtime, seen_verdict.is_free, seen_verdict.bad_period,
                           seen_verdict.too_long);
               end
            end
         end
      end
   end

   // Watchdog: a run in which nothing moves on either side for too long is a hang.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("Simulation FAILED");
      $finish;
   end

endmodule

`default_nettype wire
